// ===== rtl/bpa_pkg.sv =====
// package for the binary page allocator
// holds page state codes, status codes and size constants; no dependencies
package bpa_pkg;

  localparam int unsigned MinPageLog = 8;
  localparam int unsigned ArenaLog   = 16;
  localparam int unsigned SizeW      = 17;
  localparam int unsigned OffW       = 16;

  typedef enum logic [1:0] {
    PS_ABSENT   = 2'd0,
    PS_VACANT   = 2'd1,
    PS_SPLIT    = 2'd2,
    PS_OCCUPIED = 2'd3
  } page_state_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_BAD_OFF = 2'd2
  } status_e;

  // ceil(log2(bytes)), zero and one give zero
  function automatic logic [4:0] size_log(input logic [SizeW-1:0] bytes);
    logic [4:0] r;
    r = 5'd0;
    for (int i = SizeW; i >= 0; i--) begin
      if (((SizeW+1)'(1) << i) >= {1'b0, bytes}) r = 5'(i);
    end
    return r;
  endfunction

endpackage

// ===== rtl/binary_page_allocator_top.sv =====
// binary page allocator top level
// buddy page tree held in one synchronous memory; depends on bpa_pkg
//
// channel  dir  fields
// s_axis   in   tdata: mode[0], req_size[17:1], free_offset[33:18]
// m_axis   out  tdata: page_offset[15:0], status[17:16]
//
// one item at a time; an allocation scans one node at a time from the
// first node of its level upward, reading each node (S_SCAN) and checking it
// (S_CHECK), then passes S_SPLIT, S_SPL2 and S_SPL3 once per split level; a
// free goes straight to the result. after reset a clearing pass writes every
// node, one per cycle, before the first item is taken. a waiting result
// stalls the next item.
module binary_page_allocator_top #(
  parameter int unsigned MIN_PAGE_LOG = bpa_pkg::MinPageLog,
  parameter int unsigned ARENA_LOG    = bpa_pkg::ArenaLog
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // mode, req_size, free_offset
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // page_offset, status
);
  import bpa_pkg::*;

  localparam int unsigned Levels = (ARENA_LOG > MIN_PAGE_LOG) ? ARENA_LOG - MIN_PAGE_LOG : 0;
  localparam int unsigned Nodes  = (2 << Levels) - 1;
  localparam int unsigned AW     = $clog2(Nodes + 1);
  localparam int unsigned NW     = AW + 1;

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_SCAN = 4'd2,
                         S_CHECK = 4'd3, S_SPLIT = 4'd4, S_SPL2 = 4'd5,
                         S_SPL3 = 4'd6, S_MARK = 4'd7, S_OUT = 4'd8,
                         S_NEXT = 4'd9;

  logic [1:0]    mem_q [Nodes];
  logic [AW-1:0] raddr;
  logic [1:0]    rdata_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [1:0]    wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  logic [3:0]    state_q, state_d;
  logic [NW-1:0] n_q, n_d, last_q, last_d;
  logic [5:0]    d_q, d_d, goal_d_q, goal_d_d;
  logic [OffW-1:0] off_q, off_d;
  logic [1:0]    st_q, st_d;

  logic          in_mode;
  logic [SizeW-1:0] in_size;
  logic [OffW-1:0]  in_off;
  logic [5:0]    goal;
  logic [5:0]    gd;
  logic [NW-1:0] fnode;
  logic [NW+OffW:0] offcalc;

  assign in_mode = s_axis_tdata[0];
  assign in_size = s_axis_tdata[17:1];
  assign in_off  = s_axis_tdata[33:18];

  always_comb begin
    goal = {1'b0, size_log(in_size)};
    if (goal < 6'(MIN_PAGE_LOG)) goal = 6'(MIN_PAGE_LOG);
    gd = (goal >= 6'(ARENA_LOG)) ? 6'd0 : 6'(ARENA_LOG) - goal;
    if (gd > 6'(Levels)) gd = 6'(Levels);
    fnode = NW'((NW'(1) << gd) - NW'(1)) + NW'({17'd0, in_off} >> (6'(ARENA_LOG) - gd));
    offcalc = (NW+OffW+1)'(n_q - NW'((NW'(1) << d_q) - NW'(1))) << (6'(ARENA_LOG) - d_q);
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, st_q, off_q};

  always_comb begin
    state_d = state_q; n_d = n_q; last_d = last_q; d_d = d_q; goal_d_d = goal_d_q;
    off_d = off_q; st_d = st_q;
    we = 1'b0; waddr = n_q[AW-1:0]; wdata = PS_ABSENT; raddr = n_q[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        wdata = (n_q == '0) ? PS_VACANT : PS_ABSENT;
        n_d = n_q + NW'(1);
        if (n_q == NW'(Nodes - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          off_d = '0;
          if (in_mode) begin
            state_d = S_OUT;
            if ({1'b0, in_off} >= 17'(1 << ARENA_LOG)) st_d = ST_BAD_OFF;
            else begin
              st_d = ST_OK; we = 1'b1; waddr = fnode[AW-1:0]; wdata = PS_VACANT;
            end
          end else if (goal > 6'(ARENA_LOG)) begin
            st_d = ST_NO_FIT; state_d = S_OUT;
          end else begin
            d_d = 6'(ARENA_LOG) - goal;
            goal_d_d = d_d;
            if (d_d > 6'(Levels)) d_d = 6'(Levels);
            n_d = NW'((NW'(1) << d_d) - NW'(1));
            last_d = NW'((NW'(2) << d_d) - NW'(1));
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: state_d = S_CHECK;
      S_CHECK: begin
        if (rdata_q == PS_VACANT) state_d = S_SPLIT;
        else if (n_q + NW'(1) != last_q) begin
          n_d = n_q + NW'(1); state_d = S_SCAN;
        end else if (d_q != 6'd0) begin
          d_d = d_q - 6'd1;
          n_d = NW'((NW'(1) << d_d) - NW'(1));
          last_d = NW'((NW'(2) << d_d) - NW'(1));
          state_d = S_SCAN;
        end else begin
          st_d = ST_NO_FIT; state_d = S_OUT;
        end
      end
      S_SPLIT: begin
        if (d_q < goal_d_q && d_q < 6'(Levels)) begin
          we = 1'b1; wdata = PS_SPLIT; state_d = S_SPL2;
        end else state_d = S_MARK;
      end
      S_SPL2: begin
        we = 1'b1; waddr = AW'({n_q, 1'b0} + NW'(2)); wdata = PS_VACANT;
        state_d = S_SPL3;
      end
      S_SPL3: begin
        we = 1'b1; waddr = AW'({n_q, 1'b0} + NW'(1)); wdata = PS_VACANT;
        n_d = NW'({n_q, 1'b0} + NW'(1)); d_d = d_q + 6'd1;
        state_d = S_SPLIT;
      end
      S_MARK: begin
        we = 1'b1; wdata = PS_OCCUPIED;
        off_d = offcalc[OffW-1:0]; st_d = ST_OK; state_d = S_OUT;
      end
      S_OUT: if (m_axis_tready) state_d = S_NEXT;
      S_NEXT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; n_q <= '0; last_q <= '0; d_q <= '0; goal_d_q <= '0;
      st_q <= ST_OK;
    end else begin
      state_q <= state_d; n_q <= n_d; last_q <= last_d; d_q <= d_d;
      goal_d_q <= goal_d_d; st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) off_q <= off_d;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during result");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17:16] != ST_OK |-> m_axis_tdata[15:0] == '0)
    else $error("offset on failure");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule

// ===== dv/binary_page_allocator_top_test.sv =====
// self-checking testbench for binary_page_allocator_top
// a local page tree predicts every result; random handshake gaps on both channels
// depends on bpa_pkg and rtl/binary_page_allocator_top.sv
module binary_page_allocator_top_test;
  import bpa_pkg::*;

  localparam int unsigned Levels = ArenaLog - MinPageLog;
  localparam int unsigned Nodes = (2 << Levels) - 1;
  localparam int unsigned IdleLimit = 50000;
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE = 1'b1;

  typedef struct packed {
    logic [OffW-1:0] page_offset;
    status_e status;
  } page_result_t;

  typedef struct packed {
    logic [OffW-1:0] offset;
    logic [SizeW-1:0] size;
  } held_page_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [23:0] m_axis_tdata;

  page_state_e page_tree [Nodes];
  page_result_t expected_results[$];
  held_page_t held_pages[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned burst_left;

  binary_page_allocator_top i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned page_goal_log(logic [SizeW-1:0] bytes);
    int unsigned g;
    g = 0;
    for (int i = 31; i >= 0; i--) begin
      if ((64'd1 << i) >= {47'd0, bytes}) g = i;
    end
    return (g < MinPageLog) ? MinPageLog : g;
  endfunction

  function automatic page_result_t predict_page_op(logic mode, logic [SizeW-1:0] size,
                                                   logic [OffW-1:0] offset);
    page_result_t r;
    int unsigned goal;
    int unsigned d;
    int unsigned n;
    int unsigned depth;
    bit found;
    goal = page_goal_log(size);
    r.page_offset = '0;
    r.status = ST_OK;
    found = 1'b0;
    if (mode == MODE_FREE) begin
      d = (goal >= ArenaLog) ? 0 : ArenaLog - goal;
      if (d > Levels) d = Levels;
      n = ((1 << d) - 1) + (offset >> (ArenaLog - d));
      if (n < Nodes) page_tree[n] = PS_VACANT;
      return r;
    end
    for (int unsigned g = goal; g <= ArenaLog && !found; g++) begin
      d = ArenaLog - g;
      if (d <= Levels) begin
        for (n = (1 << d) - 1; n < (2 << d) - 1 && !found; n++) begin
          if (page_tree[n] == PS_VACANT) begin
            found = 1'b1;
            depth = d;
            while (depth < ArenaLog - goal && depth < Levels) begin
              page_tree[n] = PS_SPLIT;
              page_tree[2*n+1] = PS_VACANT;
              page_tree[2*n+2] = PS_VACANT;
              n = 2*n + 1;
              depth++;
            end
            page_tree[n] = PS_OCCUPIED;
            r.page_offset = OffW'((n - ((1 << depth) - 1)) << (ArenaLog - depth));
            break;
          end
        end
      end
    end
    if (!found) r.status = ST_NO_FIT;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // caller is at a falling edge; returns at a falling edge, with valid dropped for a random gap when a burst may end
  task automatic send_page_op(logic mode, logic [SizeW-1:0] size, logic [OffW-1:0] offset);
    page_result_t r;
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, offset, size, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    r = predict_page_op(mode, size, offset);
    expected_results.push_back(r);
    if (mode == MODE_ALLOC && r.status == ST_OK)
      held_pages.push_back('{offset: r.page_offset, size: size});
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic free_held_page();
    int unsigned k;
    held_page_t p;
    k = $urandom_range(0, held_pages.size() - 1);
    p = held_pages[k];
    held_pages.delete(k);
    send_page_op(MODE_FREE, p.size, p.offset);
  endtask

  function automatic logic [SizeW-1:0] random_page_size();
    int unsigned k;
    k = $urandom_range(0, 16);
    if ($urandom_range(0, 3) != 0) k = $urandom_range(0, 10);
    if (k == 0) return SizeW'($urandom_range(0, 1));
    return SizeW'($urandom_range((1 << (k - 1)) + 1, 1 << k));
  endfunction

  task automatic test_size_extremes();
    send_page_op(MODE_ALLOC, 17'd0, 16'hffff);
    send_page_op(MODE_ALLOC, 17'd1, 16'd0);
    send_page_op(MODE_ALLOC, 17'd256, 16'd0);
    send_page_op(MODE_ALLOC, 17'd257, 16'd0);
    send_page_op(MODE_ALLOC, 17'd65537, 16'd0);
    send_page_op(MODE_ALLOC, 17'h1ffff, 16'd0);
    send_page_op(MODE_ALLOC, 17'd65536, 16'd0);
    // unaligned free, then free beyond arena size frees the root
    send_page_op(MODE_FREE, 17'd512, 16'h01ff);
    send_page_op(MODE_FREE, 17'h1ffff, 16'hffff);
    send_page_op(MODE_ALLOC, 17'd65536, 16'd0);
    send_page_op(MODE_ALLOC, 17'd1, 16'd0);
    send_page_op(MODE_FREE, 17'd0, 16'hffff);
    send_page_op(MODE_FREE, 17'd32768, 16'h8000);
    drain_results();
  endtask

  task automatic test_fill_arena();
    held_pages.delete();
    send_page_op(MODE_FREE, 17'd65536, 16'd0);
    for (int i = 0; i < 8; i++) send_page_op(MODE_ALLOC, 17'd8192, 16'd0);
    send_page_op(MODE_ALLOC, 17'd256, 16'd0);
    send_page_op(MODE_FREE, 17'd8192, 16'he000);
    send_page_op(MODE_ALLOC, 17'd100, 16'd0);
    send_page_op(MODE_ALLOC, 17'd4096, 16'd0);
    drain_results();
  endtask

  task automatic test_random_traffic(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        if (held_pages.size() != 0 && $urandom_range(0, 1) == 0) free_held_page();
        else send_page_op(MODE_ALLOC, random_page_size(), 16'($urandom));
      end else begin
        send_page_op(1'($urandom), 17'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 199) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    error_count = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    foreach (page_tree[i]) page_tree[i] = PS_ABSENT;
    page_tree[0] = PS_VACANT;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_size_extremes();
    test_fill_arena();
    test_random_traffic(1150);
    repeat (100) @(negedge clk_i);
    if (error_count == 0) $display("binary_page_allocator_top test passed");
    else $display("binary_page_allocator_top test failed");
    $finish;
  end

  // receiver stall pattern
  initial begin
    int unsigned mode_left;
    int unsigned stall_mode;
    m_axis_tready = 1'b0;
    mode_left = 0;
    stall_mode = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode_left = $urandom_range(5, 60);
        stall_mode = $urandom_range(0, 3);
      end
      mode_left--;
      case (stall_mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = ($urandom_range(0, 3) != 0);
        2: m_axis_tready = (mode_left % 4 == 0);
        default: m_axis_tready = ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    page_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[15:0] !== want.page_offset)
          report_mismatch("page_offset", m_axis_tdata[15:0], want.page_offset);
        if (m_axis_tdata[17:16] !== want.status)
          report_mismatch("status", m_axis_tdata[17:16], want.status);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("binary_page_allocator_top test failed");
        $finish;
      end
    end
  end

  initial idle_cycles = 0;

endmodule
